@@ design/gec_pkg.sv @@
// Shared types, register offsets and request codes for the GPIO edge-interrupt controller.
package gec_pkg;

    // Request kinds
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_PIN   = 2'd2;

    // Only full-word accesses act
    localparam logic [3:0] ACCESS_WORD = 4'd4;

    // Register map, byte offsets
    localparam logic [11:0] OFF_DIRECTION  = 12'h000;
    localparam logic [11:0] OFF_OPEN_DRAIN = 12'h004;
    localparam logic [11:0] OFF_DATA       = 12'h008;
    localparam logic [11:0] OFF_EVENT      = 12'h00C;
    localparam logic [11:0] OFF_MASK       = 12'h010;
    localparam logic [11:0] OFF_CONTROL    = 12'h014;

    // Pin 0 sits in the most significant bit
    localparam logic [31:0] PIN0_MASK = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] bus_offset;
        logic [3:0]  access_size;
        logic [31:0] write_data;
        logic [4:0]  pin_index;
        logic        pin_level;
    } gec_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_line;
        logic [31:0] out_levels;
        logic [31:0] out_changed;
    } gec_rsp_t;

endpackage

@@ design/gec_stream_if.sv @@
// Valid/ready stream interface carrying one payload per handshake.
interface gec_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/gpio_controller_edge_irq.sv @@
// 32-pin GPIO controller with bus register access and edge interrupts.
//
//   channel  | role | payload
//   ---------+------+---------------------------------------------------
//   request  | sink | mode, bus_offset, access_size, write_data, pin_index, pin_level
//   result   | src  | read_data, irq_line, out_levels, out_changed
//
// One request per cycle while the result is not stalled; each accepted request goes
// through the request register, then the register update and the result register.
// Reset clears all six GPIO registers and both valid flags.
// A stalled result holds the result register; the request register still
// takes one more request, after which ready drops until the result is taken.
module gpio_controller_edge_irq (
    input  logic         clk,
    input  logic         rst_n,
    gec_stream_if.sink   request,
    gec_stream_if.source result
);
    import gec_pkg::*;

    // Pipeline registers
    gec_req_t    req_reg;
    logic        req_valid_reg;
    gec_rsp_t    rsp_reg;
    gec_rsp_t    rsp_next;
    logic        rsp_valid_reg;
    logic        advance;

    // GPIO registers
    logic [31:0] direction_reg;
    logic [31:0] direction_next;
    logic [31:0] open_drain_reg;
    logic [31:0] open_drain_next;
    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic [31:0] event_reg;
    logic [31:0] event_next;
    logic [31:0] mask_reg;
    logic [31:0] mask_next;
    logic [31:0] control_reg;
    logic [31:0] control_next;

    logic [31:0] pin_bit;

    // Handshake: the held request moves on when the result slot is free
    assign advance       = req_valid_reg && (!rsp_valid_reg || result.ready);
    assign request.ready = !req_valid_reg || advance;
    assign result.valid  = rsp_valid_reg;
    assign result.payload = rsp_reg;

    assign pin_bit = PIN0_MASK >> req_reg.pin_index;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            req_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            req_reg <= request.payload;
        end
    end

    // Read-modify-write of the register file and result build
    always_comb
    begin
        direction_next  = direction_reg;
        open_drain_next = open_drain_reg;
        data_next       = data_reg;
        event_next      = event_reg;
        mask_next       = mask_reg;
        control_next    = control_reg;
        rsp_next        = '0;

        case (req_reg.mode)
            MODE_READ:
            begin
                if (req_reg.access_size == ACCESS_WORD)
                begin
                    case (req_reg.bus_offset)
                        OFF_DIRECTION:  rsp_next.read_data = direction_reg;
                        OFF_OPEN_DRAIN: rsp_next.read_data = open_drain_reg;
                        OFF_DATA:       rsp_next.read_data = data_reg;
                        OFF_EVENT:      rsp_next.read_data = event_reg;
                        OFF_MASK:       rsp_next.read_data = mask_reg;
                        OFF_CONTROL:    rsp_next.read_data = control_reg;
                        default:        rsp_next.read_data = '0;
                    endcase
                end
            end
            MODE_WRITE:
            begin
                if (req_reg.access_size == ACCESS_WORD)
                begin
                    case (req_reg.bus_offset)
                        OFF_DIRECTION:  direction_next  = req_reg.write_data;
                        OFF_OPEN_DRAIN: open_drain_next = req_reg.write_data;
                        OFF_DATA:
                        begin
                            rsp_next.out_changed = (data_reg ^ req_reg.write_data)
                                                   & direction_reg;
                            data_next = req_reg.write_data;
                        end
                        OFF_EVENT:      event_next   = event_reg & ~req_reg.write_data;
                        OFF_MASK:       mask_next    = req_reg.write_data;
                        OFF_CONTROL:    control_next = req_reg.write_data;
                        default:        ;
                    endcase
                end
            end
            MODE_PIN:
            begin
                // events on output pins are ignored
                if ((direction_reg & pin_bit) == '0)
                begin
                    data_next = req_reg.pin_level ? (data_reg | pin_bit)
                                                  : (data_reg & ~pin_bit);
                    // any event, or falling edge only when the control bit is set
                    if (((control_reg & pin_bit) == '0) ||
                        (((data_reg & pin_bit) != '0) && !req_reg.pin_level))
                    begin
                        event_next = event_reg | pin_bit;
                    end
                end
            end
            default: ;
        endcase

        rsp_next.irq_line   = |(event_next & mask_next);
        rsp_next.out_levels = data_next;
    end

    // GPIO register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg  <= '0;
            open_drain_reg <= '0;
            data_reg       <= '0;
            event_reg      <= '0;
            mask_reg       <= '0;
            control_reg    <= '0;
        end
        else if (advance)
        begin
            direction_reg  <= direction_next;
            open_drain_reg <= open_drain_next;
            data_reg       <= data_next;
            event_reg      <= event_next;
            mask_reg       <= mask_next;
            control_reg    <= control_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef SYNTH
    // Interrupt flag in the result matches the event and mask registers after the request
    a_irq_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_reg.irq_line == (|(event_reg & mask_reg)))
        else $error("irq_line disagrees with event and mask registers");

    // Reported levels are the data register after the request
    a_levels_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_reg.out_levels == data_reg)
        else $error("out_levels disagrees with data register");

    // Changed pins are always output-direction pins
    a_changed_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.out_changed & ~direction_reg) == '0)
        else $error("out_changed reports an input pin");

    // A held request cannot be overwritten while it waits
    a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !advance) |=> req_valid_reg && $stable(req_reg))
        else $error("waiting request lost or changed");
`endif

endmodule
